[rtl/core/hrr_pkg.sv]
// shared constants and types for the hue rotate recolor block
`timescale 1ns / 1ps

package hrr_pkg;

  // hue in degrees with 8 fraction bits, below 360*256
  localparam int HUE_W  = 17;
  // position inside one 60 degree sector, below 15360
  localparam int FRAC_W = 14;
  // quotient width of the long divider
  localparam int QUO_W  = 16;
  // divider steps per pipeline stage
  localparam int DIV_PER = 4;

  localparam logic [HUE_W-1:0] DEG60_FX  = 17'd15360;
  localparam logic [HUE_W-1:0] DEG120_FX = 17'd30720;
  localparam logic [HUE_W-1:0] DEG180_FX = 17'd46080;
  localparam logic [HUE_W-1:0] DEG240_FX = 17'd61440;
  localparam logic [HUE_W-1:0] DEG300_FX = 17'd76800;
  localparam logic [HUE_W-1:0] DEG360_FX = 17'd92160;
  localparam logic [HUE_W:0]   DEG720_FX = 18'd184320;

  localparam logic [HUE_W-1:0] BIAS_RED   = 17'd0;
  localparam logic [HUE_W-1:0] BIAS_GREEN = 17'd30720;
  localparam logic [HUE_W-1:0] BIAS_BLUE  = 17'd61440;

  // 255 * 256
  localparam int SAT_SCALE = 65280;

  // ceil(2^32 / 255), exact for products below 2^24
  localparam logic [24:0] RECIP_255    = 25'd16843010;
  localparam int          RECIP_255_SH = 32;
  // 15360 = 15 << 10; ceil(2^24 / 15), exact below 2^20
  localparam int          DEG60_SH     = 10;
  localparam logic [20:0] RECIP_15     = 21'd1118482;
  localparam int          RECIP_15_SH  = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SAT   = 2'd1;
  localparam logic [8:0] HUE_OFFSET_RST = 9'd300;
  localparam logic [7:0] GRAY_SAT_RST   = 8'd128;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

endpackage

[rtl/core/hrr_in_if.sv]
// input color channel: valid, ready and one rgb color
`timescale 1ns / 1ps

interface hrr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

[rtl/core/hrr_out_if.sv]
// result channel: valid, ready and one recolored rgb color with gray flag
`timescale 1ns / 1ps

interface hrr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       was_gray;

  modport source (output valid, out_red, out_green, out_blue, was_gray, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, was_gray, output ready);
endinterface

[rtl/core/hrr_div.sv]
// pipelined two-lane restoring divider with sideband
`timescale 1ns / 1ps

module hrr_div #(
  parameter int DW  = 8,
  parameter int QW  = 16,
  parameter int SW  = 1,
  parameter int PER = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [1:0][DW+QW-1:0]    num,
  input  logic [1:0][DW-1:0]       den,
  input  logic [SW-1:0]            side,
  output logic                     out_valid,
  output logic [1:0][QW-1:0]       quo,
  output logic [SW-1:0]            out_side
);

  localparam int NS = QW / PER;

  logic                v    [NS+1];
  logic [1:0][QW-1:0]  low  [NS+1];
  logic [SW-1:0]       sd   [NS+1];
  logic [1:0][DW-1:0]  rem  [NS];
  logic [1:0][DW-1:0]  dv   [NS];

  // top bits of the numerator start as the partial remainder, below the divisor
  assign v[0]   = in_valid;
  assign sd[0]  = side;
  assign dv[0]  = den;
  assign rem[0] = {num[1][DW+QW-1:QW], num[0][DW+QW-1:QW]};
  assign low[0] = {num[1][QW-1:0], num[0][QW-1:0]};

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [1:0][DW-1:0] rem_next;
    logic [1:0][QW-1:0] low_next;

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] rr;
      logic [QW-1:0] ll;
      rem_next = rem[k];
      low_next = low[k];
      t  = '0;
      rr = '0;
      ll = '0;
      for (int l = 0; l < 2; l++) begin
        rr = rem[k][l];
        ll = low[k][l];
        for (int i = 0; i < PER; i++) begin
          t  = {rr, ll[QW-1]};
          ll = {ll[QW-2:0], 1'b0};
          if (t >= {1'b0, dv[k][l]}) begin
            t     = t - {1'b0, dv[k][l]};
            ll[0] = 1'b1;
          end
          rr = t[DW-1:0];
        end
        rem_next[l] = rr;
        low_next[l] = ll;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        low[k+1] <= low_next;
        sd[k+1]  <= sd[k];
      end
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= rem_next;
          dv[k+1]  <= dv[k];
        end
      end
    end
  end

  assign out_valid = v[NS];
  assign quo       = low[NS];
  assign out_side  = sd[NS];

endmodule

[rtl/core/hue_rotate_recolor.sv]
// top level: rgb to hsv, hue rotation or gray tint, hsv back to rgb
`timescale 1ns / 1ps

// One rgb color enters per cycle and one recolored color leaves per cycle while the
// output is not stalled. A color passes one stage for max/min and the leading channel,
// four for the hue and saturation divider at four quotient bits a stage, seven for
// hue unwrap, rotation, the two constant-reciprocal divisions and the ramp products,
// and one output register. The whole pipe advances together
// whenever the output register is empty or its beat is taken, so ready follows
// out ready with no extra latency. Gray inputs keep hue 0 and take gray_saturation;
// other colors get hue_offset added modulo 360. Configuration writes are taken at
// any time but should land while no color is in flight.
module hue_rotate_recolor import hrr_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  hrr_in_if.sink                pix_in,
  hrr_out_if.source             pix_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // channels come in on 8 bits, so anything beyond 8 masks nothing
  localparam int W     = (CHANNEL_BITS < 8) ? CHANNEL_BITS : 8;
  localparam int NW    = W + QUO_W;         // divider numerator
  localparam int SW    = 2 + HUE_W + W;     // gray, neg, bias, value
  localparam int PW    = QUO_W + W;         // saturation times value
  localparam int SPW   = PW - 7;            // spread before clamp
  localparam int MF_W  = W + 8;             // channel with 8 fraction bits
  localparam int RP_W  = FRAC_W + MF_W;     // ramp product
  localparam int Y_W   = RP_W - DEG60_SH;   // ramp product over 1024
  localparam int HP_W  = Y_W + 21;          // times reciprocal of 15
  localparam int EP_W  = PW + 25;           // times reciprocal of 255

  // configuration registers
  logic [8:0] hue_offset;
  logic [7:0] gray_saturation;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset      <= HUE_OFFSET_RST;
      gray_saturation <= GRAY_SAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUE_OFFSET: hue_offset      <= cfg_data[8:0];
        CFG_GRAY_SAT:   gray_saturation <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // global advance: output register free or being drained
  logic en;
  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  // ---------------------------------------------------------------- stage 1
  // max, min, which channel leads, and the two numerators
  logic [W-1:0]       r, g, b, mx, mn, x, y, d, mag;
  logic [HUE_W-1:0]   bias;
  logic               gray, neg;

  assign r    = pix_in.in_red[W-1:0];
  assign g    = pix_in.in_green[W-1:0];
  assign b    = pix_in.in_blue[W-1:0];
  assign gray = (r == g) && (g == b);

  always_comb begin
    if (r >= g && r >= b) begin
      mx = r; mn = (g <= b) ? g : b; x = g; y = b; bias = BIAS_RED;
    end else if (g >= r && g >= b) begin
      mx = g; mn = (r <= b) ? r : b; x = b; y = r; bias = BIAS_GREEN;
    end else begin
      mx = b; mn = (r <= g) ? r : g; x = r; y = g; bias = BIAS_BLUE;
    end
    d   = mx - mn;
    neg = x < y;
    mag = neg ? (y - x) : (x - y);
  end

  logic              s1_valid;
  logic [NW-1:0]     s1_num_h, s1_num_s;
  logic [W-1:0]      s1_den_h, s1_den_s;
  logic [SW-1:0]     s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num_h <= NW'(mag) * NW'(DEG60_FX);
      s1_num_s <= NW'(d) * NW'(SAT_SCALE);
      s1_den_h <= d;
      s1_den_s <= mx;
      s1_side  <= {gray, neg, bias, mx};
    end
  end

  // ---------------------------------------------------------------- divider
  // lane 0: hue quotient within a sector, lane 1: saturation
  logic                  dq_valid;
  logic [1:0][QUO_W-1:0] dq_quo;
  logic [SW-1:0]         dq_side;

  hrr_div #(
    .DW  (W),
    .QW  (QUO_W),
    .SW  (SW),
    .PER (DIV_PER)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .num       ({s1_num_s, s1_num_h}),
    .den       ({s1_den_s, s1_den_h}),
    .side      (s1_side),
    .out_valid (dq_valid),
    .quo       (dq_quo),
    .out_side  (dq_side)
  );

  // ---------------------------------------------------------------- stage 2
  // add the sector bias, wrap negative hue into range
  logic               dq_gray, dq_neg;
  logic [HUE_W-1:0]   dq_bias, dq_q, hue_raw, hue_wrap;
  logic [W-1:0]       dq_v;

  assign dq_gray = dq_side[SW-1];
  assign dq_neg  = dq_side[SW-2];
  assign dq_bias = dq_side[W+HUE_W-1:W];
  assign dq_v    = dq_side[W-1:0];
  assign dq_q    = HUE_W'(dq_quo[0]);

  always_comb begin
    if (!dq_neg) begin
      hue_raw = dq_bias + dq_q;
    end else if (dq_q > dq_bias) begin
      hue_raw = DEG360_FX - (dq_q - dq_bias);
    end else begin
      hue_raw = dq_bias - dq_q;
    end
    hue_wrap = (hue_raw >= DEG360_FX) ? (hue_raw - DEG360_FX) : hue_raw;
  end

  logic               s2_valid, s2_gray;
  logic [HUE_W-1:0]   s2_h;
  logic [QUO_W-1:0]   s2_s;
  logic [W-1:0]       s2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_h    <= hue_wrap;
      s2_s    <= dq_quo[1];
      s2_v    <= dq_v;
      s2_gray <= dq_gray;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // rotation modulo 360, gray override
  logic [HUE_W:0]     rot_sum;
  logic [HUE_W-1:0]   rot_h;

  assign rot_sum = {1'b0, s2_h} + (HUE_W+1)'({hue_offset, 8'd0});

  always_comb begin
    if (rot_sum >= DEG720_FX) begin
      rot_h = HUE_W'(rot_sum - DEG720_FX);
    end else if (rot_sum >= {1'b0, DEG360_FX}) begin
      rot_h = HUE_W'(rot_sum - {1'b0, DEG360_FX});
    end else begin
      rot_h = rot_sum[HUE_W-1:0];
    end
  end

  logic               s3_valid, s3_gray;
  logic [HUE_W-1:0]   s3_h;
  logic [QUO_W-1:0]   s3_s;
  logic [W-1:0]       s3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_h    <= s2_gray ? '0 : rot_h;
      s3_s    <= s2_gray ? {gray_saturation, 8'd0} : s2_s;
      s3_v    <= s2_v;
      s3_gray <= s2_gray;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // saturation times value, sector and offset inside it
  sector_t            sector;
  logic [HUE_W-1:0]   sec_base;

  always_comb begin
    if (s3_h >= DEG300_FX) begin
      sector = SEC_5; sec_base = DEG300_FX;
    end else if (s3_h >= DEG240_FX) begin
      sector = SEC_4; sec_base = DEG240_FX;
    end else if (s3_h >= DEG180_FX) begin
      sector = SEC_3; sec_base = DEG180_FX;
    end else if (s3_h >= DEG120_FX) begin
      sector = SEC_2; sec_base = DEG120_FX;
    end else if (s3_h >= DEG60_FX) begin
      sector = SEC_1; sec_base = DEG60_FX;
    end else begin
      sector = SEC_0; sec_base = '0;
    end
  end

  logic               s4_valid, s4_gray;
  logic [PW-1:0]      s4_p;
  sector_t            s4_sector;
  logic [FRAC_W-1:0]  s4_f;
  logic [W-1:0]       s4_v;
  logic [HUE_W-1:0]   f_full;

  assign f_full = s3_h - sec_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_p      <= PW'(s3_s) * PW'(s3_v);
      s4_sector <= sector;
      s4_f      <= f_full[FRAC_W-1:0];
      s4_v      <= s3_v;
      s4_gray   <= s3_gray;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // spread = product / 255 by reciprocal
  logic [EP_W-1:0]    spread_prod;
  assign spread_prod = EP_W'(s4_p) * EP_W'(RECIP_255);

  logic               s5_valid, s5_gray;
  logic [SPW-1:0]     s5_spread;
  sector_t            s5_sector;
  logic [FRAC_W-1:0]  s5_f;
  logic [W-1:0]       s5_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_spread <= spread_prod[EP_W-1:RECIP_255_SH];
      s5_sector <= s4_sector;
      s5_f      <= s4_f;
      s5_v      <= s4_v;
      s5_gray   <= s4_gray;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // clamp spread to max, derive min and the falling fraction
  logic [MF_W-1:0]    maxf, spread_c;
  assign maxf     = {s5_v, 8'd0};
  assign spread_c = (s5_spread > SPW'(maxf)) ? maxf : s5_spread[MF_W-1:0];

  logic               s6_valid, s6_gray;
  logic [MF_W-1:0]    s6_spread, s6_minf, s6_maxf;
  logic [FRAC_W-1:0]  s6_f, s6_fm;
  sector_t            s6_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_spread <= spread_c;
      s6_minf   <= maxf - spread_c;
      s6_maxf   <= maxf;
      s6_f      <= s5_f;
      s6_fm     <= DEG60_FX[FRAC_W-1:0] - s5_f;
      s6_sector <= s5_sector;
      s6_gray   <= s5_gray;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // ramp products for the rising and falling channel
  logic               s7_valid, s7_gray;
  logic [RP_W-1:0]    s7_rp, s7_fp;
  logic [MF_W-1:0]    s7_minf, s7_maxf;
  sector_t            s7_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_rp     <= RP_W'(s6_f) * RP_W'(s6_spread);
      s7_fp     <= RP_W'(s6_fm) * RP_W'(s6_spread);
      s7_minf   <= s6_minf;
      s7_maxf   <= s6_maxf;
      s7_sector <= s6_sector;
      s7_gray   <= s6_gray;
    end
  end

  // ---------------------------------------------------------------- stage 8
  // divide by 15360: drop 10 bits, then reciprocal of 15
  logic [HP_W-1:0]    rise_prod, fall_prod;
  assign rise_prod = HP_W'(s7_rp[RP_W-1:DEG60_SH]) * HP_W'(RECIP_15);
  assign fall_prod = HP_W'(s7_fp[RP_W-1:DEG60_SH]) * HP_W'(RECIP_15);

  logic               s8_valid, s8_gray;
  logic [MF_W-1:0]    s8_qr, s8_qf, s8_minf, s8_maxf;
  sector_t            s8_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_qr     <= rise_prod[RECIP_15_SH+MF_W-1:RECIP_15_SH];
      s8_qf     <= fall_prod[RECIP_15_SH+MF_W-1:RECIP_15_SH];
      s8_minf   <= s7_minf;
      s8_maxf   <= s7_maxf;
      s8_sector <= s7_sector;
      s8_gray   <= s7_gray;
    end
  end

  // ---------------------------------------------------------------- output
  // sector mux, truncate fraction bits
  logic [MF_W-1:0] rise, fall, rf, gf, bf;
  assign rise = s8_qr + s8_minf;
  assign fall = s8_qf + s8_minf;

  always_comb begin
    case (s8_sector)
      SEC_0:   begin rf = s8_maxf; gf = rise;    bf = s8_minf; end
      SEC_1:   begin rf = fall;    gf = s8_maxf; bf = s8_minf; end
      SEC_2:   begin rf = s8_minf; gf = s8_maxf; bf = rise;    end
      SEC_3:   begin rf = s8_minf; gf = fall;    bf = s8_maxf; end
      SEC_4:   begin rf = rise;    gf = s8_minf; bf = s8_maxf; end
      default: begin rf = s8_maxf; gf = s8_minf; bf = fall;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (en) begin
      pix_out.valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out.out_red   <= 8'(rf[MF_W-1:8]);
      pix_out.out_green <= 8'(gf[MF_W-1:8]);
      pix_out.out_blue  <= 8'(bf[MF_W-1:8]);
      pix_out.was_gray  <= s8_gray;
    end
  end

endmodule

[bench/hrr_bench_if.sv]
// bench interface bundling the configuration write port
`timescale 1ns / 1ps

interface hrr_cfg_if;
  logic                          we;
  logic [hrr_pkg::CFG_IDX_W-1:0] index;
  logic [hrr_pkg::CFG_DATA_W-1:0] data;
endinterface

[bench/tb.sv]
// testbench for hue_rotate_recolor: predicted recolor results checked beat by beat
`timescale 1ns / 1ps

module tb import hrr_pkg::*; ();

  // recolored color as the block should deliver it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       gray;
  } recolor_t;

  logic clk;
  logic rst;

  hrr_in_if  pix_in ();
  hrr_out_if pix_out ();
  hrr_cfg_if cfg ();

  hue_rotate_recolor dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg.we),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
  );

  // bench copy of the two registers
  logic [8:0] offset_q;
  logic [7:0] gray_sat_q;

  recolor_t pending_colors[$];
  int       mismatches;
  int       idle_cycles;
  bit       timed_out;
  // receiver behavior: 0 random gaps, 1 always ready, 2 long hold-off
  int       sink_mode;
  int       hold_cycles;

  localparam int IDLE_LIMIT = 2000;
  // pipe depth plus margin
  localparam int DRAIN_CYCLES = 30;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hsv round trip of one color under the current registers
  function automatic recolor_t recolor(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned rr, gg, bb;
    longint unsigned h, s, v, mx, mn, x, y, bias, d, q;
    longint unsigned spread, maxf, minf, sect, f, rise, fall, rf, gf, bf;
    recolor_t res;
    rr = 64'(r);
    gg = 64'(g);
    bb = 64'(b);
    res.gray = (rr == gg) && (gg == bb);
    if (res.gray) begin
      h = 0;
      s = 64'(gray_sat_q) << 8;
      v = rr;
    end else begin
      if (rr >= gg && rr >= bb) begin
        mx = rr; mn = (gg <= bb) ? gg : bb; x = gg; y = bb; bias = 0;
      end else if (gg >= rr && gg >= bb) begin
        mx = gg; mn = (rr <= bb) ? rr : bb; x = bb; y = rr; bias = 30720;
      end else begin
        mx = bb; mn = (rr <= gg) ? rr : gg; x = rr; y = gg; bias = 61440;
      end
      d = mx - mn;
      if (x >= y) begin
        q = (15360 * (x - y)) / d;
        h = bias + q;
      end else begin
        q = (15360 * (y - x)) / d;
        h = (q > bias) ? 92160 - (q - bias) : bias - q;
      end
      if (h >= 92160) h = h - 92160;
      s = (d * 65280) / mx;
      v = mx;
      h = (h + 64'(offset_q) * 256) % 92160;
    end
    spread = (s * v) / 255;
    maxf = v << 8;
    if (spread > maxf) spread = maxf;
    minf = maxf - spread;
    sect = h / 15360;
    f = h % 15360;
    rise = (f * spread) / 15360 + minf;
    fall = ((15360 - f) * spread) / 15360 + minf;
    case (sect)
      0: begin rf = maxf; gf = rise; bf = minf; end
      1: begin rf = fall; gf = maxf; bf = minf; end
      2: begin rf = minf; gf = maxf; bf = rise; end
      3: begin rf = minf; gf = fall; bf = maxf; end
      4: begin rf = rise; gf = minf; bf = maxf; end
      default: begin rf = maxf; gf = minf; bf = fall; end
    endcase
    res.red   = 8'(rf >> 8);
    res.green = 8'(gf >> 8);
    res.blue  = 8'(bf >> 8);
    return res;
  endfunction

  function automatic int gap_len();
    // mostly short, sometimes long
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // one input beat; prediction is queued at acceptance
  // valid stays high on return so the next beat can follow at once
  task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_in.valid    <= 1'b1;
    pix_in.in_red   <= r;
    pix_in.in_green <= g;
    pix_in.in_blue  <= b;
    do @(posedge clk); while (!pix_in.ready);
    pending_colors.push_back(recolor(r, g, b));
    @(negedge clk);
  endtask

  task automatic send_gapped(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
    int n;
    send_color(r, g, b);
    if (gaps) begin
      n = gap_len();
      if (n > 0) begin
        pix_in.valid <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, only with the pipe empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
    cfg.we    <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(negedge clk);
    cfg.we <= 1'b0;
    if (idx == CFG_HUE_OFFSET) offset_q = val;
    else if (idx == CFG_GRAY_SAT) gray_sat_q = val[7:0];
    @(negedge clk);
  endtask

  task automatic test_directed();
    // channel extremes, all-zero and full gray, each dominant channel, ties
    send_color(8'd0, 8'd0, 8'd0);
    send_color(8'd255, 8'd255, 8'd255);
    send_color(8'd1, 8'd1, 8'd1);
    send_color(8'd255, 8'd0, 8'd0);
    send_color(8'd0, 8'd255, 8'd0);
    send_color(8'd0, 8'd0, 8'd255);
    send_color(8'd255, 8'd255, 8'd0);
    send_color(8'd0, 8'd255, 8'd255);
    send_color(8'd255, 8'd0, 8'd255);
    send_color(8'd255, 8'd254, 8'd0);
    send_color(8'd255, 8'd0, 8'd254);
    send_color(8'd1, 8'd0, 8'd0);
    send_color(8'd10, 8'd200, 8'd30);
    send_color(8'd30, 8'd10, 8'd200);
    send_color(8'd128, 8'd127, 8'd128);
    send_color(8'h55, 8'haa, 8'h55);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // offset 0 and 359, gray saturation 0 and 255, plus offsets above 359
    logic [8:0] offs[5] = '{9'd0, 9'd359, 9'd1, 9'd511, 9'd360};
    logic [7:0] sats[5] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd200};
    for (int k = 0; k < 5; k++) begin
      write_reg(CFG_HUE_OFFSET, offs[k]);
      write_reg(CFG_GRAY_SAT, {1'b0, sats[k]});
      send_color(8'd200, 8'd100, 8'd50);
      send_color(8'd77, 8'd77, 8'd77);
      send_color(8'd20, 8'd40, 8'd250);
      wait_drained();
    end
  endtask

  task automatic test_random_stream(int n);
    logic [7:0] r, g, b;
    for (int i = 0; i < n; i++) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      // some grays and two-channel ties
      case ($urandom_range(0, 7))
        0: begin g = r; b = r; end
        1: g = r;
        2: b = g;
        default: ;
      endcase
      send_gapped(r, g, b, 1'b1);
    end
  endtask

  task automatic test_random_config();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_HUE_OFFSET, 9'($urandom));
      write_reg(CFG_GRAY_SAT, 9'($urandom_range(0, 255)));
      test_random_stream(135);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    // receiver stalls long while colors keep coming, so the pipe fills
    hold_cycles = 60;
    sink_mode   = 2;
    for (int i = 0; i < 40; i++) send_color(8'($urandom), 8'($urandom), 8'($urandom));
    // back to back with receiver always ready
    sink_mode = 1;
    for (int i = 0; i < 40; i++) send_color(8'($urandom), 8'($urandom), 8'($urandom));
    sink_mode = 0;
    wait_drained();
  endtask

  // receiver ready, changed on falling edges
  initial begin
    int n;
    pix_out.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_mode == 2) begin
        pix_out.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        sink_mode = 0;
      end else if (sink_mode == 1) begin
        pix_out.ready <= 1'b1;
        @(negedge clk);
      end else begin
        n = gap_len();
        if (n == 0) begin
          pix_out.ready <= 1'b1;
          @(negedge clk);
        end else begin
          pix_out.ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    recolor_t want;
    recolor_t got;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.was_gray};
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_colors.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    mismatches   = 0;
    idle_cycles  = 0;
    sink_mode    = 0;
    hold_cycles  = 0;
    pix_in.valid = 1'b0;
    pix_in.in_red = '0; pix_in.in_green = '0; pix_in.in_blue = '0;
    cfg.we = 1'b0; cfg.index = '0; cfg.data = '0;
    offset_q   = HUE_OFFSET_RST;
    gray_sat_q = GRAY_SAT_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_config();
    wait_drained();

    if (mismatches == 0 && pending_colors.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

[files.f]
rtl/core/hrr_pkg.sv
rtl/core/hrr_in_if.sv
rtl/core/hrr_out_if.sv
rtl/core/hrr_div.sv
rtl/core/hue_rotate_recolor.sv
bench/hrr_bench_if.sv
bench/tb.sv
